@@ rtl/stop_wait_receiver_ones_sum_check_macros.svh @@
// Assertion macros for the stop-and-wait receiver.
// Used by stop_wait_receiver_ones_sum_check; expects clk_i and rst_ni in scope.
`ifndef STOP_WAIT_RECEIVER_ONES_SUM_CHECK_MACROS_SVH
`define STOP_WAIT_RECEIVER_ONES_SUM_CHECK_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SWR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("receiver assertion failed");

// Next-cycle implication, checked out of reset.
`define SWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("receiver assertion failed");

`endif

@@ rtl/swr_pkg.sv @@
// Package for the stop-and-wait receiver: item types, op codes, constants.
// No dependencies; imported by stop_wait_receiver_ones_sum_check.
package swr_pkg;

  localparam int MaxPayload = 1024;
  localparam int SeqW       = 32;
  localparam int LenW       = 11;
  localparam int ByteW      = 8;
  // Compare width wide enough for any payload limit up to 65535
  localparam int CmpW       = 17;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } swr_op_e;

  typedef struct packed {
    swr_op_e           op;
    logic [SeqW-1:0]   seq_num;
    logic [ByteW-1:0]  check_word;
    logic [LenW-1:0]   payload_length;
    logic [ByteW-1:0]  data_byte;
  } swr_in_t;

  typedef struct packed {
    logic              accepted;
    logic [SeqW-1:0]   packet_seq;
    logic              transfer_done;
  } swr_out_t;

  // 8-bit ones' complement add with end-around carry
  function automatic logic [ByteW-1:0] oc_add(input logic [ByteW-1:0] a,
                                              input logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
  endfunction

endpackage

@@ rtl/stop_wait_receiver_ones_sum_check.sv @@
// Top level of the stop-and-wait receiver with 8-bit ones' complement check.
// Depends on swr_pkg and stop_wait_receiver_ones_sum_check_macros.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------
//  in      | input     | in_valid_i/in_ready_o   | swr_pkg::swr_in_t
//  out     | output    | out_valid_o/out_ready_i | swr_pkg::swr_out_t
//
// One item per cycle unless a held result stalls: an item enters the input
// register; a single pass of logic (two 8-bit end-around adds and a 32-bit
// sequence compare) updates the packet state and loads the result register.
// A judged packet shows on out_o after the input and result registers.
// Reset (rst_ni low, async) clears valids and state but held seq and check.
// A held result stalls the input register, which then drops in_ready_o.
`include "stop_wait_receiver_ones_sum_check_macros.svh"

module stop_wait_receiver_ones_sum_check (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  swr_pkg::swr_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swr_pkg::swr_out_t out_o
);
  import swr_pkg::*;

  // Input register
  logic    in_valid_q;
  swr_in_t in_q;

  // Packet state
  logic [SeqW-1:0]  expected_count_q, expected_count_d;
  logic [ByteW-1:0] running_sum_q, running_sum_d;
  logic [SeqW-1:0]  held_seq_q, held_seq_d;
  logic [ByteW-1:0] held_check_q, held_check_d;
  logic [LenW-1:0]  held_length_q, held_length_d;
  logic [LenW-1:0]  bytes_seen_q, bytes_seen_d;
  logic             finished_q, finished_d;

  // Result register
  logic     out_valid_q;
  swr_out_t out_q;

  // Working signals
  logic             proc_en;
  logic             judge;
  logic [ByteW-1:0] j_sum;
  logic [ByteW-1:0] j_check;
  logic [SeqW-1:0]  j_seq;
  logic [LenW-1:0]  j_len;
  logic [ByteW-1:0] j_total;
  logic [SeqW-1:0]  want_seq;
  logic             j_ok;
  logic             j_done;
  logic [ByteW-1:0] data_sum;
  logic [LenW-1:0]  bytes_inc;
  logic             res_load;
  swr_out_t         res;

  // Advance the input register when the result slot is free or being drained
  assign proc_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // Accumulate the data byte and count it
  assign data_sum  = oc_add(running_sum_q, in_q.data_byte);
  assign bytes_inc = bytes_seen_q + LenW'(1);

  // Decode the item and pick the packet to judge
  always_comb begin
    expected_count_d = expected_count_q;
    running_sum_d    = running_sum_q;
    held_seq_d       = held_seq_q;
    held_check_d     = held_check_q;
    held_length_d    = held_length_q;
    bytes_seen_d     = bytes_seen_q;
    finished_d       = finished_q;
    judge            = 1'b0;
    j_sum            = running_sum_q;
    j_check          = held_check_q;
    j_seq            = held_seq_q;
    j_len            = held_length_q;

    if (proc_en && !finished_q) begin
      unique case (in_q.op)
        OP_HEADER: begin
          held_seq_d    = in_q.seq_num;
          held_check_d  = in_q.check_word;
          held_length_d = in_q.payload_length;
          bytes_seen_d  = '0;
          running_sum_d = '0;
          // Empty payload is judged at once
          judge         = (in_q.payload_length == '0);
          j_sum         = '0;
          j_check       = in_q.check_word;
          j_seq         = in_q.seq_num;
          j_len         = in_q.payload_length;
        end
        OP_DATA: begin
          // Drop data with no open packet
          if (bytes_seen_q < held_length_q) begin
            running_sum_d = data_sum;
            bytes_seen_d  = bytes_inc;
            judge         = (bytes_inc == held_length_q);
            j_sum         = data_sum;
          end
        end
        default: ;
      endcase
    end

    // Judge: add the check word, compare sequence, advance the count, clear the packet
    j_total  = oc_add(j_sum, j_check);
    want_seq = expected_count_q + SeqW'(1);
    j_ok     = (j_total == '1) && (j_seq == want_seq);
    j_done   = j_ok && ({{(CmpW-LenW){1'b0}}, j_len} < CmpW'(MaxPayload));

    if (judge) begin
      if (j_ok) begin
        expected_count_d = want_seq;
      end
      if (j_done) begin
        finished_d = 1'b1;
      end
      running_sum_d = '0;
      held_length_d = '0;
      bytes_seen_d  = '0;
    end
  end

  assign res_load          = judge;
  assign res.accepted      = j_ok;
  assign res.packet_seq    = j_seq;
  assign res.transfer_done = j_done;

  // Update the packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_count_q <= '0;
      running_sum_q    <= '0;
      held_length_q    <= '0;
      bytes_seen_q     <= '0;
      finished_q       <= 1'b0;
    end else begin
      expected_count_q <= expected_count_d;
      running_sum_q    <= running_sum_d;
      held_length_q    <= held_length_d;
      bytes_seen_q     <= bytes_seen_d;
      finished_q       <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_seq_q   <= held_seq_d;
    held_check_q <= held_check_d;
  end

  // Hold the result until taken; load a new one when judged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks
  `SWR_ASSERT_IMPL(a_no_result_after_end, finished_q, !res_load)
  `SWR_ASSERT_IMPL(a_count_bounded, 1'b1, bytes_seen_q <= held_length_q)
  `SWR_ASSERT_NEXT(a_done_sets_finished, res_load && res.transfer_done, finished_q)
  `SWR_ASSERT_NEXT(a_ack_advances, res_load && res.accepted,
                   expected_count_q == $past(expected_count_q) + SeqW'(1))

endmodule
